/* rtl/e2c_pkg.sv */
// Shared types, constants and small tables for the epoch-to-calendar converter.
// No dependencies; the sequencer, datapath, top level and both test files import this package.
package e2c_pkg;

  localparam int unsigned RemW  = 18;  // wide enough for the 400-year divisor
  localparam int unsigned StepW = 4;

  // Constant division: reciprocal multiply on a 64-bit working value, then one fix-up.
  localparam int unsigned WorkW   = 64;
  localparam int unsigned FoldW   = RemW + 2;  // holds a remainder below twice the divisor
  localparam int unsigned DivCntW = 3;

  localparam logic [DivCntW-1:0] DivFold = DivCntW'(4);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(5);

  localparam logic [StepW-1:0] LastStep = StepW'(12);

  localparam logic [RemW-1:0] SecPerMin    = RemW'(60);
  localparam logic [RemW-1:0] MinPerHour   = RemW'(60);
  localparam logic [RemW-1:0] HourPerDay   = RemW'(24);
  localparam logic [RemW-1:0] DaysPerWeek  = RemW'(7);
  localparam logic [RemW-1:0] DaysPerCycle = RemW'(146097);

  // floor(2^64 / d); none of the divisors is a power of two.
  localparam logic [WorkW-1:0] AllOnes    = '1;
  localparam logic [WorkW-1:0] RecipSixty = AllOnes / WorkW'(60);
  localparam logic [WorkW-1:0] RecipHours = AllOnes / WorkW'(24);
  localparam logic [WorkW-1:0] RecipWeek  = AllOnes / WorkW'(7);
  localparam logic [WorkW-1:0] RecipCycle = AllOnes / WorkW'(146097);

  localparam logic [11:0] YearBase      = 12'd70;   // 1970 - 1900
  localparam logic [11:0] YearsPerCycle = 12'd400;
  localparam logic [8:0]  YearBaseMod   = 9'd370;   // 1970 mod 400
  localparam logic [8:0]  CycleLastYear = 9'd399;
  localparam logic [2:0]  WdayOffset    = 3'd4;     // the epoch day was a Thursday
  localparam logic [3:0]  MonthsPerYear = 4'd12;
  localparam logic [3:0]  LastMonth     = 4'd11;
  localparam logic [8:0]  DaysCommon    = 9'd365;
  localparam logic [8:0]  DaysLeap      = 9'd366;

  typedef enum logic [3:0] {
    OP_WAIT_IN,
    OP_DIV,
    OP_WDAY_PREP,
    OP_CYC_PREP,
    OP_YEAR_INIT,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_CLAMP,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    DSEL_SEC,
    DSEL_MIN,
    DSEL_HOUR,
    DSEL_WEEK,
    DSEL_CYCLE
  } dsel_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_YEAR_MORE,
    COND_MONTH_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    dsel_e            dsel;
    cond_e            cond;
    logic [StepW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic div_done;
    logic year_more;
    logic month_more;
  } dp_status_t;

  typedef struct packed {
    dp_status_t dp;
    logic       in_fire;
    logic       out_free;
  } status_t;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [11:0] years_since_1900;
    logic [8:0]  day_of_year;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
  } result_t;

  function automatic logic [RemW-1:0] divisor(input dsel_e sel);
    logic [RemW-1:0] d;
    case (sel)
      DSEL_SEC:   d = SecPerMin;
      DSEL_MIN:   d = MinPerHour;
      DSEL_HOUR:  d = HourPerDay;
      DSEL_WEEK:  d = DaysPerWeek;
      DSEL_CYCLE: d = DaysPerCycle;
      default:    d = DaysPerCycle;
    endcase
    return d;
  endfunction

  function automatic logic [WorkW-1:0] reciprocal(input dsel_e sel);
    logic [WorkW-1:0] m;
    case (sel)
      DSEL_SEC:   m = RecipSixty;
      DSEL_MIN:   m = RecipSixty;
      DSEL_HOUR:  m = RecipHours;
      DSEL_WEEK:  m = RecipWeek;
      DSEL_CYCLE: m = RecipCycle;
      default:    m = RecipCycle;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/e2c_in_if.sv */
// Input channel of the epoch-to-calendar converter: valid/ready plus the epoch.
// Depends on nothing; the width follows the converter's epoch width.
interface e2c_in_if #(
  parameter int unsigned WIDTH = 36
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

/* rtl/e2c_out_if.sv */
// Result channel of the epoch-to-calendar converter: valid/ready plus the fields.
// Depends on nothing.
interface e2c_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  second;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;
  logic [11:0] years_since_1900;
  logic [8:0]  day_of_year;
  logic [3:0]  month_index;
  logic [4:0]  day_of_month;

  modport source (output valid, output second, output minute, output hour, output weekday,
                  output years_since_1900, output day_of_year, output month_index,
                  output day_of_month, input ready);
  modport sink   (input valid, input second, input minute, input hour, input weekday,
                  input years_since_1900, input day_of_year, input month_index,
                  input day_of_month, output ready);
endinterface

/* rtl/e2c_sequencer.sv */
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on e2c_pkg.
module e2c_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  e2c_pkg::status_t status_i,
  output e2c_pkg::ctrl_t   ctrl_o
);
  import e2c_pkg::*;

  logic [StepW-1:0] step_q, step_d;
  ctrl_t            ctrl;
  logic             hold;
  logic             take_jump;

  function automatic ctrl_t rom(input logic [StepW-1:0] step);
    ctrl_t w;
    w = '{op: OP_WAIT_IN, dsel: DSEL_SEC, cond: COND_NONE, target: '0};
    case (step)
      4'd0:  w = '{op: OP_WAIT_IN,    dsel: DSEL_SEC,   cond: COND_NONE,       target: '0};
      4'd1:  w = '{op: OP_DIV,        dsel: DSEL_SEC,   cond: COND_NONE,       target: '0};
      4'd2:  w = '{op: OP_DIV,        dsel: DSEL_MIN,   cond: COND_NONE,       target: '0};
      4'd3:  w = '{op: OP_DIV,        dsel: DSEL_HOUR,  cond: COND_NONE,       target: '0};
      4'd4:  w = '{op: OP_WDAY_PREP,  dsel: DSEL_SEC,   cond: COND_NONE,       target: '0};
      4'd5:  w = '{op: OP_DIV,        dsel: DSEL_WEEK,  cond: COND_NONE,       target: '0};
      4'd6:  w = '{op: OP_CYC_PREP,   dsel: DSEL_SEC,   cond: COND_NONE,       target: '0};
      4'd7:  w = '{op: OP_DIV,        dsel: DSEL_CYCLE, cond: COND_NONE,       target: '0};
      4'd8:  w = '{op: OP_YEAR_INIT,  dsel: DSEL_SEC,   cond: COND_NONE,       target: '0};
      4'd9:  w = '{op: OP_YEAR_STEP,  dsel: DSEL_SEC,   cond: COND_YEAR_MORE,  target: 4'd9};
      4'd10: w = '{op: OP_MONTH_STEP, dsel: DSEL_SEC,   cond: COND_MONTH_MORE, target: 4'd10};
      4'd11: w = '{op: OP_CLAMP,      dsel: DSEL_SEC,   cond: COND_NONE,       target: '0};
      4'd12: w = '{op: OP_EMIT,       dsel: DSEL_SEC,   cond: COND_ALWAYS,     target: '0};
      default: w = '{op: OP_WAIT_IN,  dsel: DSEL_SEC,   cond: COND_ALWAYS,     target: '0};
    endcase
    return w;
  endfunction

  // Outputs: the control word of the current step.
  always_comb begin
    ctrl = rom(step_q);
  end
  assign ctrl_o = ctrl;

  // Next step: hold while waiting for input, a division or a free result register, else jump or advance.
  always_comb begin
    case (ctrl.op)
      OP_WAIT_IN: hold = !status_i.in_fire;
      OP_DIV:     hold = !status_i.dp.div_done;
      OP_EMIT:    hold = !status_i.out_free;
      default:    hold = 1'b0;
    endcase
    case (ctrl.cond)
      COND_ALWAYS:     take_jump = 1'b1;
      COND_YEAR_MORE:  take_jump = status_i.dp.year_more;
      COND_MONTH_MORE: take_jump = status_i.dp.month_more;
      default:         take_jump = 1'b0;
    endcase
    if (hold) begin
      step_d = step_q;
    end else if (take_jump) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= LastStep) else $error("step counter beyond program");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_DIV && !status_i.dp.div_done) |=> $stable(step_q))
    else $error("step moved before division finished");

  a_emit_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == OP_EMIT && status_i.out_free) |=> step_q == '0)
    else $error("emit did not return to the idle step");

endmodule

/* rtl/e2c_datapath.sv */
// Datapath: reciprocal-multiply constant divider, year and month counters, result fields.
// Depends on e2c_pkg; driven step by step by e2c_sequencer.
module e2c_datapath #(
  parameter int unsigned EPOCH_WIDTH = 36
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  e2c_pkg::ctrl_t         ctrl_i,
  input  logic                   in_fire_i,
  input  logic [EPOCH_WIDTH-1:0] epoch_i,
  output e2c_pkg::dp_status_t    status_o,
  output e2c_pkg::result_t       result_o
);
  import e2c_pkg::*;

  logic [WorkW-1:0]   num_q, keep_q;
  logic [2*WorkW-1:0] acc_q;
  logic [FoldW-1:0]   rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic [RemW-1:0]    days_q;
  logic [11:0]        year_q;
  logic [8:0]         y400_q;
  logic [8:0]         doy_q;
  logic [3:0]         month_q;
  logic [5:0]         sec_q, min_q;
  logic [4:0]         hour_q;
  logic [2:0]         wday_q;

  logic [RemW-1:0]    dvs;
  logic [WorkW-1:0]   rcp;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        pp;
  logic [2*WorkW-1:0] pp_sh;
  logic [WorkW-1:0]   q_est;
  logic [FoldW-1:0]   prod_lo;
  logic [FoldW-1:0]   rem_est;
  logic               rem_over;
  logic [FoldW-1:0]   rem_fix;
  logic               div_done;
  logic               leap;
  logic [RemW-1:0]    ylen;
  logic [4:0]         mlen;
  logic               year_more, month_more;

  // Four 32x32 partial products build num * floor(2^64 / d); the top half of the sum is
  // the quotient or one below it. Fold the remainder on its low bits, then fix up once.
  always_comb begin
    dvs   = divisor(ctrl_i.dsel);
    rcp   = reciprocal(ctrl_i.dsel);
    mul_a = cnt_q[0] ? num_q[63:32] : num_q[31:0];
    mul_b = cnt_q[1] ? rcp[63:32] : rcp[31:0];
    pp    = WorkW'(mul_a) * WorkW'(mul_b);
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
    q_est    = acc_q[2*WorkW-1:WorkW];
    prod_lo  = q_est[FoldW-1:0] * FoldW'(dvs);
    rem_est  = num_q[FoldW-1:0] - prod_lo;
    rem_over = (rem_q >= FoldW'(dvs));
    rem_fix  = rem_over ? (rem_q - FoldW'(dvs)) : rem_q;
  end

  assign div_done = (ctrl_i.op == OP_DIV) && (cnt_q == DivLast);

  // Gregorian rule on the year within its 400-year cycle.
  always_comb begin
    leap = ((y400_q[1:0] == 2'd0) && (y400_q != 9'd100) && (y400_q != 9'd200)
            && (y400_q != 9'd300)) || (y400_q == 9'd0);
    ylen = leap ? RemW'(DaysLeap) : RemW'(DaysCommon);
    mlen = month_len(month_q, leap);
    year_more  = (days_q >= ylen);
    month_more = (month_q < MonthsPerYear) && (days_q >= RemW'(mlen));
  end

  assign status_o = '{div_done: div_done, year_more: year_more, month_more: month_more};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.op == OP_DIV) begin
      cnt_q <= div_done ? '0 : cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_WAIT_IN: begin
        acc_q <= '0;
        if (in_fire_i) begin
          num_q <= WorkW'(epoch_i);
        end
      end
      OP_DIV: begin
        if (cnt_q < DivFold) begin
          acc_q <= acc_q + pp_sh;
        end else if (!div_done) begin
          num_q <= q_est;
          rem_q <= rem_est;
        end else begin
          acc_q <= '0;
          num_q <= num_q + WorkW'(rem_over);
          case (ctrl_i.dsel)
            DSEL_SEC:   sec_q  <= rem_fix[5:0];
            DSEL_MIN:   min_q  <= rem_fix[5:0];
            DSEL_HOUR:  hour_q <= rem_fix[4:0];
            DSEL_WEEK:  wday_q <= rem_fix[2:0];
            DSEL_CYCLE: days_q <= rem_fix[RemW-1:0];
            default:    days_q <= rem_fix[RemW-1:0];
          endcase
        end
      end
      OP_WDAY_PREP: begin
        keep_q <= num_q;
        num_q  <= num_q + WorkW'(WdayOffset);
      end
      OP_CYC_PREP: begin
        num_q <= keep_q;
      end
      OP_YEAR_INIT: begin
        // Whole cycles counted in the quotient; the year field wraps at 12 bits.
        year_q  <= YearBase + 12'(num_q[11:0] * YearsPerCycle);
        y400_q  <= YearBaseMod;
        month_q <= '0;
      end
      OP_YEAR_STEP: begin
        if (year_more) begin
          days_q <= days_q - ylen;
          year_q <= year_q + 12'd1;
          y400_q <= (y400_q == CycleLastYear) ? 9'd0 : y400_q + 9'd1;
        end else begin
          doy_q <= days_q[8:0];
        end
      end
      OP_MONTH_STEP: begin
        if (month_more) begin
          days_q  <= days_q - RemW'(mlen);
          month_q <= month_q + 4'd1;
        end
      end
      OP_CLAMP: begin
        // Past December: pin to the last day of December.
        if (month_q >= MonthsPerYear) begin
          month_q <= LastMonth;
          days_q  <= RemW'(month_len(LastMonth, leap)) - RemW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign result_o = '{
    second:           sec_q,
    minute:           min_q,
    hour:             hour_q,
    weekday:          wday_q,
    years_since_1900: year_q,
    day_of_year:      doy_q,
    month_index:      month_q,
    day_of_month:     days_q[4:0] + 5'd1
  };

  a_fold_below_twice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (rem_q < (FoldW'(dvs) << 1))) else $error("quotient estimate off by more than one");

  a_y400_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_YEAR_STEP) |-> (y400_q <= CycleLastYear))
    else $error("year within cycle out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_MONTH_STEP) |-> (month_q <= MonthsPerYear))
    else $error("month counter out of range");

endmodule

/* rtl/epoch_seconds_to_calendar.sv */
// Top level of the epoch-to-calendar converter: sequencer, datapath, result register.
// Depends on e2c_pkg, e2c_in_if, e2c_out_if, e2c_sequencer and e2c_datapath.
//
// Usage
//   in_ch_i carries an unsigned count of seconds since 1970-01-01 00:00 UTC; a transfer
//   happens when valid and ready are both high. out_ch_o carries one result per input:
//   second, minute, hour, weekday (Sunday 0), year minus 1900 (wrapping at 12 bits),
//   day of year, month (January 0) and day of month (from 1).
//   One item is worked on at a time: ready is high only while the sequencer sits on its
//   idle step. Five divisions by constants (60, 60, 24, 7 and 146097 days) each run
//   four reciprocal partial products, a remainder fold and a fix-up. Set-up steps, a
//   clamp and an emit step join them; the year loop repeats once per whole year left
//   after removing 400-year cycles (0 to 399), the month loop once per whole month
//   before the date (0 to 11), and each takes one more pass to leave. The next transfer
//   can follow in the cycle after the result is loaded.
//   The result sits in an output register, so the sequencer takes the next epoch while
//   the receiver stalls; it waits at its final step only if the previous result has not
//   been taken. Reset (asynchronous, active low) returns the sequencer to its idle step
//   and drops any pending result; there is no clearing pass.
module epoch_seconds_to_calendar #(
  parameter int unsigned EPOCH_WIDTH = 36
) (
  input logic      clk_i,
  input logic      rst_ni,
  e2c_in_if.sink   in_ch_i,
  e2c_out_if.source out_ch_o
);
  import e2c_pkg::*;

  ctrl_t      ctrl;
  status_t    status;
  dp_status_t dp_status;
  result_t    dp_result;
  result_t    out_q;
  logic       out_valid_q;
  logic       in_fire;
  logic       out_free;
  logic       out_load;

  // Accept an epoch only on the idle step.
  assign in_ch_i.ready = (ctrl.op == OP_WAIT_IN);
  assign in_fire       = in_ch_i.valid && in_ch_i.ready;

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_ch_o.ready;
  assign out_load = (ctrl.op == OP_EMIT) && out_free;

  assign status = '{dp: dp_status, in_fire: in_fire, out_free: out_free};

  e2c_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  e2c_datapath #(
    .EPOCH_WIDTH (EPOCH_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .in_fire_i (in_fire),
    .epoch_i   (in_ch_i.epoch_seconds),
    .status_o  (dp_status),
    .result_o  (dp_result)
  );

  // Hold the result until its transfer; advance a new one in on emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= dp_result;
    end
  end

  assign out_ch_o.valid            = out_valid_q;
  assign out_ch_o.second           = out_q.second;
  assign out_ch_o.minute           = out_q.minute;
  assign out_ch_o.hour             = out_q.hour;
  assign out_ch_o.weekday          = out_q.weekday;
  assign out_ch_o.years_since_1900 = out_q.years_since_1900;
  assign out_ch_o.day_of_year      = out_q.day_of_year;
  assign out_ch_o.month_index      = out_q.month_index;
  assign out_ch_o.day_of_month     = out_q.day_of_month;

  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.op == OP_EMIT))
    else $error("result shown without an emit step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch_o.ready) |=> $stable(out_q))
    else $error("pending result overwritten");

  a_idle_only_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (ctrl.op == OP_DIV))
    else $error("accepted epoch did not start the divisions");

endmodule

/* test/e2c_calendar_checker.sv */
// Result checker for the epoch-to-calendar converter: predicts each date and compares it.
// Depends on e2c_pkg (result_t); fed from the testbench top with both channels' signals.
module e2c_calendar_checker #(
  parameter int unsigned EpochWidth = 36
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  epoch_valid_i,
  input  logic                  epoch_ready_i,
  input  logic [EpochWidth-1:0] epoch_i,
  input  logic                  date_valid_i,
  input  logic                  date_ready_i,
  input  e2c_pkg::result_t      date_i,
  output int unsigned           checked_o,
  output int unsigned           failures_o
);
  import e2c_pkg::*;

  localparam longint unsigned FirstYear      = 1970;
  localparam longint unsigned DaysIn400Years = 146097;
  localparam int unsigned     MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    logic [EpochWidth-1:0] epoch;
    result_t               date;
  } awaited_t;

  awaited_t awaited_dates [$];

  function automatic bit gregorian_leap(input longint unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Break a count of seconds since 1970 into UTC calendar fields.
  function automatic result_t break_down_epoch(input logic [EpochWidth-1:0] secs);
    longint unsigned t;
    longint unsigned days;
    longint unsigned yr;
    longint unsigned ylen;
    int unsigned     mon;
    int unsigned     mlen;
    bit              leap;
    result_t         r;
    t         = 64'(secs);
    r.second  = 6'(t % 60);
    t         = t / 60;
    r.minute  = 6'(t % 60);
    t         = t / 60;
    r.hour    = 5'(t % 24);
    days      = t / 24;
    r.weekday = 3'((days + 4) % 7);  // day zero was a Thursday

    // drop whole 400-year cycles, then step year by year
    yr   = FirstYear + 400 * (days / DaysIn400Years);
    days = days % DaysIn400Years;
    ylen = gregorian_leap(yr) ? 366 : 365;
    while (days >= ylen) begin
      days -= ylen;
      yr++;
      ylen = gregorian_leap(yr) ? 366 : 365;
    end
    r.years_since_1900 = 12'(yr - 1900);
    r.day_of_year      = 9'(days);

    leap = gregorian_leap(yr);
    for (mon = 0; mon < 12; mon++) begin
      mlen = MonthDays[mon] + ((mon == 1 && leap) ? 1 : 0);
      if (days < mlen) break;
      days -= mlen;
    end
    // past December: pin to the last day of the year
    if (mon >= 12) begin
      mon  = 11;
      days = MonthDays[11] - 1;
    end
    r.month_index  = 4'(mon);
    r.day_of_month = 5'(days + 1);
    return r;
  endfunction

  function automatic int unsigned field_differs(input string field, input logic [11:0] want,
                                                input logic [11:0] got,
                                                input logic [EpochWidth-1:0] epoch);
    if (got === want) return 0;
    $display("%0t: epoch %0d %s expected %0d, actual %0d", $time, epoch, field, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    awaited_t    head;
    int unsigned errs;
    if (!rst_ni) begin
      awaited_dates.delete();
      checked_o  <= 0;
      failures_o <= 0;
    end else begin
      errs = 0;
      // compare before queueing, so a result always meets the older epoch
      if (date_valid_i && date_ready_i) begin
        if (awaited_dates.size() == 0) begin
          $display("%0t: date transfer with no epoch outstanding, expected none, actual %p",
                   $time, date_i);
          errs = 1;
        end else begin
          head = awaited_dates.pop_front();
          errs += field_differs("second", 12'(head.date.second), 12'(date_i.second), head.epoch);
          errs += field_differs("minute", 12'(head.date.minute), 12'(date_i.minute), head.epoch);
          errs += field_differs("hour", 12'(head.date.hour), 12'(date_i.hour), head.epoch);
          errs += field_differs("weekday", 12'(head.date.weekday), 12'(date_i.weekday),
                                head.epoch);
          errs += field_differs("years_since_1900", head.date.years_since_1900,
                                date_i.years_since_1900, head.epoch);
          errs += field_differs("day_of_year", 12'(head.date.day_of_year),
                                12'(date_i.day_of_year), head.epoch);
          errs += field_differs("month_index", 12'(head.date.month_index),
                                12'(date_i.month_index), head.epoch);
          errs += field_differs("day_of_month", 12'(head.date.day_of_month),
                                12'(date_i.day_of_month), head.epoch);
        end
        checked_o <= checked_o + 1;
      end
      if (epoch_valid_i && epoch_ready_i) begin
        awaited_dates.push_back('{epoch: epoch_i, date: break_down_epoch(epoch_i)});
      end
      failures_o <= failures_o + errs;
    end
  end

endmodule

/* test/epoch_seconds_to_calendar_tb.sv */
// Testbench top for the epoch-to-calendar converter: clock, reset, epoch and date traffic.
// Depends on e2c_pkg, both channel interfaces, the converter and e2c_calendar_checker.
module epoch_seconds_to_calendar_tb;
  import e2c_pkg::*;

  localparam int unsigned EpochWidth   = 36;
  localparam int unsigned RandomItems  = 250;
  localparam int unsigned MaxWait      = 13;
  // Long receiver hold: far beyond one conversion, so the result register and the
  // sequencer both fill and the input side stalls.
  localparam int unsigned SinkHold     = 3000;
  // Drain a little beyond the worst conversion.
  localparam int unsigned EndDrain     = 650;
  // Longest quiet spell of a correct run is the sink hold; allow a wide margin on top.
  localparam int unsigned IdleLimit    = 10000;
  localparam longint unsigned SecPerDay = 86400;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  e2c_in_if #(.WIDTH(EpochWidth)) in_ch ();
  e2c_out_if                      out_ch ();

  epoch_seconds_to_calendar #(
    .EPOCH_WIDTH(EpochWidth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  result_t     seen_date;
  int unsigned dates_checked;
  int unsigned date_failures;

  assign seen_date = '{second:           out_ch.second,
                       minute:           out_ch.minute,
                       hour:             out_ch.hour,
                       weekday:          out_ch.weekday,
                       years_since_1900: out_ch.years_since_1900,
                       day_of_year:      out_ch.day_of_year,
                       month_index:      out_ch.month_index,
                       day_of_month:     out_ch.day_of_month};

  e2c_calendar_checker #(
    .EpochWidth(EpochWidth)
  ) i_calendar_checker (
    .clk_i,
    .rst_ni,
    .epoch_valid_i(in_ch.valid),
    .epoch_ready_i(in_ch.ready),
    .epoch_i      (in_ch.epoch_seconds),
    .date_valid_i (out_ch.valid),
    .date_ready_i (out_ch.ready),
    .date_i       (seen_date),
    .checked_o    (dates_checked),
    .failures_o   (date_failures)
  );

  // Shared between the two traffic processes: a calm stretch switches off idling on both
  // sides, and a hold request makes the receiver sit out the long SinkHold wait once.
  bit          calm_stretch;
  bit          sink_hold_req;
  int unsigned epochs_sent;
  int unsigned corner_count;

  // Days from 1970-01-01 to January 1 of the given year.
  function automatic longint unsigned year_start_day(input longint unsigned yr);
    longint unsigned p;
    longint unsigned q;
    p = yr - 1;
    q = 1969;
    return 365 * (yr - 1970) + (p / 4 - p / 100 + p / 400) - (q / 4 - q / 100 + q / 400);
  endfunction

  // Offer one epoch and hold it until the converter takes it. Keep valid high across
  // back-to-back items so it never gets two updates in one step.
  task automatic send_epoch(input longint unsigned secs);
    int unsigned gap;
    gap = calm_stretch ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.epoch_seconds <= EpochWidth'(secs);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    epochs_sent++;
  endtask

  // Epoch source: reset, corner cases, then random traffic.
  initial begin
    longint unsigned corner_epochs [$];
    longint unsigned base;
    int unsigned     hold_at;
    int unsigned     doy;
    in_ch.valid         <= 1'b0;
    in_ch.epoch_seconds <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // field extremes, every leap rule, year and 400-year boundaries
    corner_epochs = '{0, 59, 60, 3599, 3600, 86399, 86400,
                      64'h0_FFFF_FFFF, 64'h1_0000_0000, 64'h8_0000_0000, 64'hF_FFFF_FFFF,
                      64'hA_AAAA_AAAA, 64'h5_5555_5555};
    corner_epochs.push_back(SecPerDay * year_start_day(1971));           // first year step
    corner_epochs.push_back(SecPerDay * year_start_day(1973) - 1);       // leap year last second
    corner_epochs.push_back(SecPerDay * year_start_day(2000));
    corner_epochs.push_back(SecPerDay * (year_start_day(2000) + 59) + 43200);  // 29 Feb
    corner_epochs.push_back(SecPerDay * (year_start_day(2000) + 60));
    corner_epochs.push_back(SecPerDay * year_start_day(2001) - 1);       // day 365
    corner_epochs.push_back(SecPerDay * (year_start_day(2100) + 59) - 1);  // century, no leap
    corner_epochs.push_back(SecPerDay * (year_start_day(2100) + 59));
    corner_epochs.push_back(SecPerDay * year_start_day(2370) - 1);       // last year of a cycle
    corner_epochs.push_back(SecPerDay * year_start_day(2370));           // whole cycle removed
    corner_epochs.push_back(SecPerDay * (year_start_day(2400) + 59));    // leap by 400
    corner_count = corner_epochs.size();
    foreach (corner_epochs[k]) send_epoch(corner_epochs[k]);

    hold_at = $urandom_range(60, 180);
    for (int unsigned i = 0; i < RandomItems; i++) begin
      calm_stretch = (i % 50) >= 40;
      if (i == hold_at) sink_hold_req = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2: base = {$urandom(), $urandom()};       // every bit of the epoch
        3, 4:    base = $urandom();                     // within 32 bits
        5:       base = $urandom_range(0, 1 << 20);     // first days after the epoch
        default: begin
          // aim at calendar edges: year start, end of February, year end
          case ($urandom_range(0, 3))
            0:       doy = 0;
            1:       doy = $urandom_range(58, 60);
            2:       doy = $urandom_range(364, 365);
            default: doy = $urandom_range(0, 365);
          endcase
          base = SecPerDay * (year_start_day($urandom_range(1970, 4146)) + doy);
          if ($urandom_range(0, 1) && base >= 8) base -= $urandom_range(1, 8);
          else base += $urandom_range(0, 5);
        end
      endcase
      send_epoch(base);
    end
    in_ch.valid <= 1'b0;

    // wait for every date, then a conversion's worth of cycles for strays
    while (dates_checked < epochs_sent) @(posedge clk_i);
    repeat (EndDrain) @(posedge clk_i);

    $display("converted %0d epochs (%0d corner cases, %0d random), %0d dates checked,",
             epochs_sent, corner_count, RandomItems, dates_checked);
    $display("with random gaps on both sides and one %0d-cycle receiver hold", SinkHold);
    if (date_failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Date sink: draw a wait per result, or sit out the long hold when asked.
  initial begin
    int unsigned wait_cycles;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_hold_req) begin
        wait_cycles   = SinkHold;
        sink_hold_req = 1'b0;
      end else if (calm_stretch) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, MaxWait);
      end
      if (wait_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d epochs sent, %0d dates checked",
                 $time, IdleLimit, epochs_sent, dates_checked);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

/* epoch_seconds_to_calendar.f */
rtl/e2c_pkg.sv
rtl/e2c_in_if.sv
rtl/e2c_out_if.sv
rtl/e2c_sequencer.sv
rtl/e2c_datapath.sv
rtl/epoch_seconds_to_calendar.sv
test/e2c_calendar_checker.sv
test/epoch_seconds_to_calendar_tb.sv
